FILE: sv/lbwt_pkg.sv
package lbwt_pkg;

  // Map geometry and limits
  localparam int unsigned MAP_WORDS       = 16384;
  localparam int unsigned MAX_SPAN_BLOCKS = 63;
  localparam int unsigned MapAw           = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned WordW           = 64;
  localparam int unsigned BitW            = 6;

  // Field widths
  localparam int unsigned OffW  = 40;
  localparam int unsigned LenW  = 31;
  localparam int unsigned IdxW  = 20;
  localparam int unsigned CfgW  = 5;
  localparam int unsigned EndW  = OffW + 1;
  localparam int unsigned FirstW = OffW - 10;
  localparam int unsigned LastW  = EndW - 10;

  // Block size limits (log2 bytes)
  localparam logic [CfgW-1:0] BsMin   = 5'd10;
  localparam logic [CfgW-1:0] BsMax   = 5'd16;
  localparam logic [CfgW-1:0] BsReset = 5'd12;

  // Number of blocks the map can hold, and the top of block_index
  localparam logic [LastW-1:0] MapCap   = LastW'(longint'(MAP_WORDS) * 64);
  localparam logic [LastW-1:0] IndexMax = LastW'((64'd1 << IdxW) - 1);
  localparam logic [LastW-1:0] SpanMax  = LastW'(MAX_SPAN_BLOCKS);

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_SPAN = 2'd1,
    STAT_MAP  = 2'd2
  } status_e;

  // Range unit result handed to the walker
  typedef struct packed {
    logic            valid;
    logic            zero;
    status_e         status;
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] last;
  } rng_t;

endpackage

FILE: sv/lbwt_ram.sv
module lbwt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                                          clk_i,
  input  logic                                          en_i,
  input  logic                                          we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr_i,
  input  logic [WIDTH-1:0]                              wdata_i,
  output logic [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/lbwt_range.sv
module lbwt_range (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lbwt_pkg::OffW-1:0]  byte_offset_i,
  input  logic [lbwt_pkg::LenW-1:0]  byte_length_i,
  input  logic [lbwt_pkg::CfgW-1:0]  block_size_log2_i,
  output lbwt_pkg::rng_t             rng_o
);

  import lbwt_pkg::*;

  logic              p1_q, p2_q;
  logic              zero1_q, zero2_q;
  logic [OffW-1:0]   off_q;
  logic [EndW-1:0]   end_q;
  logic [FirstW-1:0] first_q;
  logic [LastW-1:0]  lastb_q;
  logic [CfgW-1:0]   sh;
  logic [LastW-1:0]  diff;
  rng_t              rng_d, rng_q;

  // clamp block size into the legal window
  always_comb begin
    if (block_size_log2_i < BsMin) begin
      sh = BsMin;
    end else if (block_size_log2_i > BsMax) begin
      sh = BsMax;
    end else begin
      sh = block_size_log2_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_q  <= 1'b0;
      p2_q  <= 1'b0;
      rng_q <= '0;
    end else begin
      p1_q  <= start_i;
      p2_q  <= p1_q;
      rng_q <= rng_d;
    end
  end

  // stage 1: end byte; stage 2: block numbers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      off_q   <= byte_offset_i;
      end_q   <= {1'b0, byte_offset_i} + EndW'(byte_length_i) - EndW'(1);
      zero1_q <= (byte_length_i == '0);
    end
    if (p1_q) begin
      first_q <= FirstW'(off_q >> sh);
      lastb_q <= LastW'(end_q >> sh);
      zero2_q <= zero1_q;
    end
  end

  // stage 3: limit checks
  assign diff = lastb_q - LastW'(first_q);

  always_comb begin
    rng_d.valid  = p2_q;
    rng_d.zero   = zero2_q;
    rng_d.first  = IdxW'(first_q);
    rng_d.last   = IdxW'(lastb_q);
    rng_d.status = STAT_OK;
    if (!zero2_q) begin
      if (diff >= SpanMax) begin
        rng_d.status = STAT_SPAN;
      end else if (lastb_q >= MapCap || lastb_q > IndexMax) begin
        rng_d.status = STAT_MAP;
      end
    end
  end

  assign rng_o = rng_q;

endmodule

FILE: sv/lazy_block_wipe_tracker.sv
// Lazy block wipe tracker. Each input beat is an access (byte offset, byte
// length); the block returns one wipe beat for every block of the access that
// has never been zeroed, in ascending block order, followed by a grant beat
// marked with tlast. The wiped bitmap lives in a 16384 x 64-bit single-port
// RAM. After reset a clearing pass zeroes the RAM one word per cycle, during
// which no access is taken (the block size register may still be written).
// Accesses are handled one at a time: accept and resolve the block range
// (offset add, shift, limit check), then for each block examined a RAM read
// followed by test and write-back, then the grant; a zero-length or rejected
// access goes straight from the range to the grant. A stall on the result
// side can hold a wipe beat or the grant. A span of more than 63 blocks is
// rejected with status 1, a block beyond the map with status 2.
module lazy_block_wipe_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // block size register (log2 bytes)
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // accesses: [39:0] byte_offset, [70:40] byte_length, [71] zero
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,
  // results: [19:0] block_index, [21:20] status, [23:22] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,
  // is_wipe
  output logic        m_axis_tuser_o,
  // last (grant)
  output logic        m_axis_tlast_o
);

  import lbwt_pkg::*;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_RANGE = 6'b000100,
    ST_READ  = 6'b001000,
    ST_TEST  = 6'b010000,
    ST_GRANT = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [CfgW-1:0]   bsize_q;
  logic [MapAw-1:0]  clr_q, clr_d;
  logic [IdxW-1:0]   cur_q, cur_d;
  logic [IdxW-1:0]   last_q, last_d;
  status_e           stat_q, stat_d;

  // result register
  logic              ovld_q, ovld_d;
  logic [IdxW-1:0]   oidx_q, oidx_d;
  logic              owipe_q, owipe_d;
  status_e           ostat_q, ostat_d;
  logic              olast_q, olast_d;
  logic              out_free;

  logic              accept;
  rng_t              rng;

  logic              ram_en, ram_we;
  logic [MapAw-1:0]  ram_addr;
  logic [WordW-1:0]  ram_wdata, ram_rdata;
  logic [MapAw-1:0]  cur_word;
  logic [WordW-1:0]  cur_mask;
  logic              cur_set;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = !ovld_q || m_axis_tready_i;

  assign cur_word = MapAw'(cur_q[IdxW-1:BitW]);
  assign cur_mask = WordW'(1) << cur_q[BitW-1:0];
  assign cur_set  = ram_rdata[cur_q[BitW-1:0]];

  lbwt_range u_range (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (accept),
    .byte_offset_i     (s_axis_tdata_i[OffW-1:0]),
    .byte_length_i     (s_axis_tdata_i[OffW+LenW-1:OffW]),
    .block_size_log2_i (bsize_q),
    .rng_o             (rng)
  );

  lbwt_ram #(
    .WIDTH (WordW),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    cur_d     = cur_q;
    last_d    = last_q;
    stat_d    = stat_q;
    ovld_d    = ovld_q & ~m_axis_tready_i;
    oidx_d    = oidx_q;
    owipe_d   = owipe_q;
    ostat_d   = ostat_q;
    olast_d   = olast_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = cur_word;
    ram_wdata = ram_rdata | cur_mask;

    case (state_q)
      ST_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + MapAw'(1);
        if (clr_q == MapAw'(MAP_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (rng.valid) begin
          cur_d  = rng.first;
          last_d = rng.last;
          stat_d = rng.status;
          if (rng.zero || rng.status != STAT_OK) begin
            state_d = ST_GRANT;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        ram_en  = 1'b1;
        state_d = ST_TEST;
      end
      ST_TEST: begin
        if (cur_set || out_free) begin
          if (!cur_set) begin
            // mark the block and send its wipe beat
            ram_en  = 1'b1;
            ram_we  = 1'b1;
            ovld_d  = 1'b1;
            oidx_d  = cur_q;
            owipe_d = 1'b1;
            ostat_d = STAT_OK;
            olast_d = 1'b0;
          end
          if (cur_q == last_q) begin
            state_d = ST_GRANT;
          end else begin
            cur_d   = cur_q + IdxW'(1);
            state_d = ST_READ;
          end
        end
      end
      ST_GRANT: begin
        if (out_free) begin
          ovld_d  = 1'b1;
          oidx_d  = '0;
          owipe_d = 1'b0;
          ostat_d = stat_q;
          olast_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      bsize_q <= BsReset;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        bsize_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    last_q  <= last_d;
    stat_q  <= stat_d;
    oidx_q  <= oidx_d;
    owipe_q <= owipe_d;
    ostat_q <= ostat_d;
    olast_q <= olast_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = {2'b00, ostat_q, oidx_q};
  assign m_axis_tuser_o  = owipe_q;
  assign m_axis_tlast_o  = olast_q;

endmodule

FILE: tb/lazy_block_wipe_tracker_tb.sv
`timescale 1ns / 100ps

module lazy_block_wipe_tracker_tb;
  import lbwt_pkg::*;

  // Run limit for the whole test, which includes the RAM clear after reset
  // and one long hold on the result side.
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned LongHold   = 400;  // result side hold-off, cycles
  localparam int unsigned Settle     = 10;   // quiet cycles after the last beat
  localparam int unsigned MaxReports = 10;
  localparam longint unsigned MapBlocks = longint'(MAP_WORDS) * 64;
  localparam longint unsigned IndexTop  = (64'd1 << IdxW) - 1;

  // One result beat: block index, wipe flag, status, grant marker.
  typedef struct packed {
    logic [IdxW-1:0] block;
    logic            wipe;
    status_e         status;
    logic            last;
  } wipe_beat_t;

  // Mirror of the wiped bitmap plus the queue of beats still owed by the DUT.
  class wipe_scoreboard;
    bit [63:0]   wiped_words [MAP_WORDS];
    logic [4:0]  blk_log2;
    wipe_beat_t  pending_q [$];
    int unsigned mismatches;

    function new();
      blk_log2   = BsReset;
      mismatches = 0;
      foreach (wiped_words[i]) wiped_words[i] = '0;
    endfunction

    // Register value clamped to the supported block sizes
    function int unsigned shift();
      if (blk_log2 < BsMin) return BsMin;
      if (blk_log2 > BsMax) return BsMax;
      return blk_log2;
    endfunction

    // Accepted access: queue one wipe per fresh block, then the grant.
    function void note_access(logic [OffW-1:0] off, logic [LenW-1:0] len);
      longint unsigned first_blk, last_blk, end_byte, b;
      int unsigned     sh;
      status_e         st;
      sh = shift();
      st = STAT_OK;
      if (len != 0) begin
        end_byte  = off;
        end_byte  = end_byte + len - 1;
        first_blk = longint'(off) >> sh;
        last_blk  = end_byte >> sh;
        if (last_blk - first_blk + 1 > MAX_SPAN_BLOCKS) begin
          st = STAT_SPAN;
        end else if (last_blk >= MapBlocks || last_blk > IndexTop) begin
          st = STAT_MAP;
        end else begin
          for (b = first_blk; b <= last_blk; b++) begin
            if (!wiped_words[b >> 6][b[5:0]]) begin
              wiped_words[b >> 6][b[5:0]] = 1'b1;
              pending_q.push_back('{block: b[IdxW-1:0], wipe: 1'b1,
                                    status: STAT_OK, last: 1'b0});
            end
          end
        end
      end
      pending_q.push_back('{block: '0, wipe: 1'b0, status: st, last: 1'b1});
    endfunction

    function void check_result(wipe_beat_t got);
      wipe_beat_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected beat: idx=%0d wipe=%0b status=%0d last=%0b",
                   got.block, got.wipe, got.status, got.last);
        return;
      end
      want = pending_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("beat mismatch: expected idx=%0d wipe=%0b status=%0d last=%0b, %s",
                   want.block, want.wipe, want.status, want.last,
                   $sformatf("got idx=%0d wipe=%0b status=%0d last=%0b",
                             got.block, got.wipe, got.status, got.last));
      end
    endfunction
  endclass

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [4:0]  cfg_wdata = '0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  wipe_scoreboard sb;
  bit          fast_mode  = 1'b0;  // no idling on either side
  bit          hold_req   = 1'b0;  // ask the result side for one long hold
  int unsigned stall_left = 0;     // result side cycles still to hold off
  int unsigned cycles     = 0;

  lazy_block_wipe_tracker dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result side: tready changes on the falling edge only. A hold-off is
  // counted down here, one cycle per falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Result monitor: sample on the rising edge, then draw the next hold-off.
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      sb.check_result({m_tdata[IdxW-1:0], m_tuser, m_tdata[21:20], m_tlast});
      if (hold_req) begin
        stall_left = LongHold;
        hold_req   = 1'b0;
      end else begin
        stall_left = fast_mode ? 0 : $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one access beat after a random gap and wait for it to be taken.
  // The beat is noted only once accepted, so the bitmap mirror stays in order.
  task automatic send_access(input longint unsigned off, input longint unsigned len);
    int unsigned gap;
    gap = fast_mode ? 0 : $urandom_range(0, 6);
    repeat (gap) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, len[LenW-1:0], off[OffW-1:0]};
    @(posedge clk_i);
    while (!(s_tvalid && s_tready)) @(posedge clk_i);
    sb.note_access(off[OffW-1:0], len[LenW-1:0]);
  endtask

  // Stop offering and wait until every owed beat has come back.
  task automatic drain_results();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (Settle) @(negedge clk_i);
  endtask

  // Block size changes only with the pipe empty.
  task automatic write_block_size(input logic [4:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    sb.blk_log2 = value;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Random access: mostly well-formed ranges inside a hot window (so blocks
  // get revisited and partially wiped ranges show up), some anywhere in the
  // map, some exactly at or one past the span limit, plus zero lengths and
  // raw noise that mostly lands on the error paths.
  task automatic random_access(input longint unsigned hot_base);
    longint unsigned blk, off, len;
    int unsigned     sh, pick;
    sh   = sb.shift();
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      blk = hot_base + $urandom_range(0, 511);
      off = (blk << sh) + $urandom_range(0, (1 << sh) - 1);
      len = $urandom_range(1, 48 << sh);
    end else if (pick < 70) begin
      blk = $urandom_range(0, IndexTop - 64);
      off = (blk << sh) + $urandom_range(0, (1 << sh) - 1);
      len = $urandom_range(1, 62 << sh);
    end else if (pick < 78) begin
      off = {$urandom(), $urandom()};
      len = 0;
    end else if (pick < 86) begin
      // 63 blocks, or 64 which must be refused
      blk = $urandom_range(0, IndexTop - 64);
      off = blk << sh;
      len = (63 << sh) + $urandom_range(0, 1);
    end else begin
      off = {$urandom(), $urandom()};
      len = pick[0] ? $urandom() : $urandom_range(1, 1 << 20);
    end
    send_access(off, len);
  endtask

  initial begin : stimulus
    logic [4:0]      phase_size [8];
    longint unsigned hot_base;
    phase_size = '{5'd10, 5'd16, 5'd12, 5'd0, 5'd31, 5'd13, 5'd11, 5'd15};
    sb = new();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, reset block size of 4 KiB
    send_access(0, 0);                                  // zero length
    send_access(40'hFF_FFFF_FFFF, 0);                   // zero length, top offset
    send_access(0, 1);                                  // single byte, block 0
    send_access(0, 4096);                               // block 0 already wiped
    send_access(4095, 2);                               // straddles blocks 0 and 1
    send_access(10 * 4096, 63 * 4096);                  // widest legal span
    send_access(10 * 4096 + 1, 63 * 4096);              // 64 blocks: span error
    send_access(40'hFF_FFFF_FFFF, 31'h7FFF_FFFF);       // all ones: span error
    send_access(40'hFF_FFFF_FFFF, 1);                   // far past the map
    send_access(longint'(IndexTop) * 4096, 4096);       // top block of the map
    send_access(MapBlocks * 4096, 1);                   // first block past the map
    send_access(longint'(IndexTop) * 4096 + 4095, 2);   // ends one past the map
    send_access(0, 31'h7FFF_FFFF);                      // huge length
    send_access(5 * 4096, 10 * 4096);                   // half already wiped

    // Register above the range acts as 64 KiB blocks
    write_block_size(5'd31);
    send_access((64'd1 << 36) - 1, 1);                  // top block again
    send_access(64'd1 << 36, 1);                        // past the map
    // Register below the range acts as 1 KiB blocks
    write_block_size(5'd0);
    send_access(longint'(IndexTop) << 10, 1024);
    send_access(0, 1025);

    // Random phases, one block size each. The hot window moves every phase.
    for (int p = 0; p < 8; p++) begin
      write_block_size(phase_size[p]);
      fast_mode = (p % 3 == 1);
      if (p == 2) hold_req = 1'b1;  // sender keeps offering while results back up
      hot_base = $urandom_range(0, IndexTop - 600);
      repeat (37) random_access(hot_base);
    end

    drain_results();
    if (sb.pending_q.size() != 0)
      $display("%0d expected beats never arrived", sb.pending_q.size());
    if (sb.mismatches == 0 && sb.pending_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
